// ===== hw/rtl/x931_aes_random_generator_top_assert.svh =====
// Assertion macros for the X9.31 AES random generator.
`ifndef X931_AES_RANDOM_GENERATOR_TOP_ASSERT_SVH
`define X931_AES_RANDOM_GENERATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define X931_ASSERT_IMPL(lbl, rst_n, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!rst_n) prop) else $error(msg);
`define X931_ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define X931_ASSERT_IMPL(lbl, rst_n, prop, msg)
`define X931_ASSERT_NOW(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/x931_pkg.sv =====
// Shared types, constants and AES round functions for the X9.31 generator.
package x931_pkg;
    localparam int unsigned REQ_W = 257;
    localparam int unsigned TDATA_IN_W = 256;
    localparam int unsigned TDATA_OUT_W = 128;
    localparam int unsigned ROUNDS = 10;

    typedef logic [3:0] t_round;

    typedef enum logic [0:0] {
        KIND_GENERATE = 1'b0,
        KIND_RESYNC = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC_DT,
        ST_ENC_R,
        ST_ENC_V,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_kind kind;
        logic [127:0] stamp;
        logic [127:0] seen;
    } t_req;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_q_ctl;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] s [256];
        s = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return s[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of the AES state sits at bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
        return w[127 - 8 * i -: 8];
    endfunction

    // One cipher round without the key add; last round skips MixColumns.
    function automatic logic [127:0] aes_round(input logic [127:0] b, input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] res;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4 * c] = sbox(get_byte(b, i + 4 * ((c + i) % 4)));
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4 * c] = a0 ^ al ^ xtime(a0 ^ a1);
                t[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[127 - 8 * i -: 8] = t[i];
        end
        return res;
    endfunction

    function automatic logic [7:0] rcon(input t_round r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Next round key from the previous one (four words).
    function automatic logic [127:0] next_key(input logic [127:0] k, input t_round r);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction
endpackage

// ===== hw/rtl/x931_queue.sv =====
// Two-entry request queue between the accepting front and the cipher engine.
module x931_queue import x931_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    input  logic i_pop,
    output t_req o_req,
    output logic o_valid
);
    t_req r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = r_cnt[1];
    assign o_valid = r_cnt != 2'd0;
    assign o_req = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ===== hw/rtl/x931_engine.sv =====
// Cipher engine: three chained AES-128 passes (two for a resync), one round per cycle.
module x931_engine import x931_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [127:0]  i_key,
    input  t_req          i_req,
    input  logic          i_req_valid,
    output logic          o_req_pop,
    output logic [127:0]  o_rand,
    output t_q_ctl        o_out_ctl,
    input  logic          i_out_ready
);
    t_state r_state, n_state;
    t_round r_round;
    logic [127:0] r_blk, r_rk, r_i, r_v, r_rand, r_seen, r_gen;
    t_kind r_kind;
    logic r_ovalid;
    logic [127:0] w_rnd, w_nk, w_res;
    logic w_last, w_done, w_start;

    assign w_last = r_round == t_round'(ROUNDS);
    assign w_nk = next_key(r_rk, r_round);
    assign w_rnd = aes_round(r_blk, w_last);
    assign w_res = w_rnd ^ w_nk;
    assign w_done = w_last && (r_state != ST_IDLE) && (r_state != ST_OUT);
    assign w_start = i_req_valid && (r_state == ST_IDLE);
    assign o_req_pop = w_start;
    assign o_rand = r_rand;
    assign o_out_ctl = '{valid: r_ovalid, ready: r_state == ST_IDLE};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_start) n_state = ST_ENC_DT;
            ST_ENC_DT: if (w_last) n_state = ST_ENC_R;
            ST_ENC_R: if (w_last) n_state = (r_kind == KIND_RESYNC) ? ST_IDLE : ST_ENC_V;
            ST_ENC_V: if (w_last) n_state = ST_OUT;
            ST_OUT: if (!r_ovalid || i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            r_ovalid <= 1'b0;
            r_round <= t_round'(1);
        end else begin
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            if (w_start) begin
                r_round <= t_round'(1);
            end else if (r_state != ST_IDLE && r_state != ST_OUT) begin
                r_round <= w_last ? t_round'(1) : r_round + t_round'(1);
            end
            if (r_state == ST_ENC_V && w_last) r_v <= w_res;
            if (r_state == ST_ENC_R && w_last && r_kind == KIND_RESYNC) r_v <= w_res;
            if (r_state == ST_OUT && (!r_ovalid || i_out_ready)) r_ovalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_kind <= i_req.kind;
            r_seen <= i_req.seen;
            r_blk <= i_req.stamp ^ i_key;
            r_rk <= i_key;
        end else if (r_state != ST_IDLE && r_state != ST_OUT) begin
            if (w_done) begin
                r_rk <= i_key;
                case (r_state)
                    ST_ENC_DT: begin
                        r_i <= w_res;
                        r_blk <= w_res ^ ((r_kind == KIND_RESYNC) ? r_seen : r_v) ^ i_key;
                    end
                    ST_ENC_R: begin
                        r_gen <= w_res;
                        r_blk <= w_res ^ r_i ^ i_key;
                    end
                    default: r_blk <= w_res;
                endcase
            end else begin
                r_blk <= w_res;
                r_rk <= w_nk;
            end
        end
        // Move the new block to the output only once the slot is free.
        if (r_state == ST_OUT && (!r_ovalid || i_out_ready)) r_rand <= r_gen;
    end
endmodule

// ===== hw/rtl/x931_aes_random_generator_top.sv =====
// Top level of the ANSI X9.31 random generator over AES-128.
// A generate request is taken from the queue when the engine is idle, runs three chained AES-128
// passes and then loads the output register, which raises tvalid; a resync runs two passes.
// The single round unit takes a new request only once the engine is back in idle.
// Input queue of two requests lets the slave side accept while the engine runs.
// Reset: synchronous active low; clears seed V to zero, key registers to zero, queue empty.
`include "x931_aes_random_generator_top_assert.svh"
module x931_aes_random_generator_top import x931_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: stamp_high, stamp_low, seen_high, seen_low (low bits first)
    input  logic [255:0] s_axis_tdata,
    // tuser: kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: rand_high, rand_low (low bits first)
    output logic [127:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    logic [63:0] r_key_hi, r_key_lo;
    logic q_full, q_valid, q_pop;
    t_req q_in, q_out;
    t_q_ctl w_octl;
    logic [127:0] w_rand;

    // Hold key halves; index 0 is the upper half.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'b0) r_key_hi <= i_cfg_data;
            else r_key_lo <= i_cfg_data;
        end
    end

    // Front: accept a request whenever the queue has room.
    assign s_axis_tready = !q_full;
    assign q_in = '{kind: t_kind'(s_axis_tuser),
                    stamp: {s_axis_tdata[63:0], s_axis_tdata[127:64]},
                    seen: {s_axis_tdata[191:128], s_axis_tdata[255:192]}};

    x931_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(s_axis_tvalid && s_axis_tready), .i_req(q_in), .o_full(q_full),
        .i_pop(q_pop), .o_req(q_out), .o_valid(q_valid)
    );

    // Back: engine holds its result register until taken.
    x931_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key({r_key_hi, r_key_lo}),
        .i_req(q_out), .i_req_valid(q_valid), .o_req_pop(q_pop),
        .o_rand(w_rand), .o_out_ctl(w_octl), .i_out_ready(m_axis_tready)
    );

    assign m_axis_tvalid = w_octl.valid;
    assign m_axis_tdata = {w_rand[63:0], w_rand[127:64]};

    `X931_ASSERT_IMPL(a_pop_needs_data, i_rst_n, q_pop |-> q_valid, "pop from empty queue")
    `X931_ASSERT_IMPL(a_out_hold, i_rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "result changed while stalled")
    `X931_ASSERT_IMPL(a_pop_idle, i_rst_n, q_pop |-> w_octl.ready, "engine took request while busy")
endmodule

// ===== tb/sv/x931_aes_random_generator_top_tb.sv =====
// Self-checking testbench for the X9.31 AES-128 random generator.
`timescale 1ns / 100ps
module x931_aes_random_generator_top_tb;
    import x931_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1450;
    localparam longint unsigned CYCLE_LIMIT = 1000000;

    typedef struct {
        t_kind kind;
        logic [127:0] stamp;
        logic [127:0] seen;
    } t_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [255:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [63:0] i_cfg_data = '0;

    x931_aes_random_generator_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: key and seed value V.
    logic [127:0] key_model;
    logic [127:0] seed_model;

    t_item pending_requests[$];
    logic [127:0] expected_rands[$];
    int unsigned error_count = 0;
    int unsigned rand_seen = 0;
    int unsigned resync_sent = 0;
    longint unsigned cycle_count = 0;
    bit burst_on = 1'b0;
    int unsigned burst_left = 0;
    int unsigned stall_phase = 0;

    // Byte-level S-box; computed from GF(2^8) inverse plus affine map.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] y;
        inv = 8'h00;
        // Inverse as x^254 by square-and-multiply.
        if (x != 8'h00) begin
            inv = 8'h01;
            for (int i = 0; i < 7; i++) begin
                inv = gf_mul(gf_mul(inv, x), 8'h01);
                inv = gf_mul(inv, inv);
            end
        end
        for (int i = 0; i < 8; i++) begin
            y[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8] ^ inv[(i + 6) % 8]
                 ^ inv[(i + 7) % 8];
        end
        return y ^ 8'h63;
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Full AES-128 encryption, byte 0 at the top of the vector.
    function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                   input logic [127:0] pt);
        logic [7:0] st [16];
        logic [7:0] sh [16];
        logic [7:0] rk [16];
        logic [7:0] tw [4];
        logic [7:0] rc;
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] ct;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127 - 8 * i -: 8];
            st[i] = pt[127 - 8 * i -: 8] ^ rk[i];
        end
        for (int r = 1; r <= 10; r++) begin
            tw[0] = sub_byte(rk[13]) ^ rc;
            tw[1] = sub_byte(rk[14]);
            tw[2] = sub_byte(rk[15]);
            tw[3] = sub_byte(rk[12]);
            for (int w = 0; w < 4; w++) begin
                for (int j = 0; j < 4; j++) begin
                    rk[4 * w + j] = rk[4 * w + j] ^ (w == 0 ? tw[j] : rk[4 * (w - 1) + j]);
                end
            end
            rc = dbl(rc);
            for (int c = 0; c < 4; c++) begin
                for (int i = 0; i < 4; i++) begin
                    sh[i + 4 * c] = sub_byte(st[i + 4 * ((c + i) % 4)]);
                end
            end
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = sh[4 * c]; a1 = sh[4 * c + 1]; a2 = sh[4 * c + 2]; a3 = sh[4 * c + 3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    sh[4 * c] = a0 ^ al ^ dbl(a0 ^ a1);
                    sh[4 * c + 1] = a1 ^ al ^ dbl(a1 ^ a2);
                    sh[4 * c + 2] = a2 ^ al ^ dbl(a2 ^ a3);
                    sh[4 * c + 3] = a3 ^ al ^ dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = sh[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++) ct[127 - 8 * i -: 8] = st[i];
        return ct;
    endfunction

    // Advance the seed model for one accepted request and queue the random block it yields.
    function automatic void predict_request(input t_item it);
        logic [127:0] enc_dt;
        logic [127:0] rnd;
        enc_dt = encrypt_block(key_model, it.stamp);
        if (it.kind == KIND_RESYNC) begin
            seed_model = encrypt_block(key_model, enc_dt ^ it.seen);
        end else begin
            rnd = encrypt_block(key_model, enc_dt ^ seed_model);
            seed_model = encrypt_block(key_model, rnd ^ enc_dt);
            expected_rands.push_back(rnd);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, rand_seen);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random 64-bit half, biased toward all-zero and all-one corners.
    function automatic logic [63:0] field64();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    function automatic t_item make_item(input t_kind k);
        t_item it;
        it.kind = k;
        it.stamp = {field64(), field64()};
        it.seen = {field64(), field64()};
        return it;
    endfunction

    // Driver: send requests in bursts, hold tvalid until the handshake completes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_request(pending_requests.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (burst_left == 0) begin
                    burst_on <= !burst_on;
                    burst_left = burst_on ? $urandom_range(1, 12) : $urandom_range(0, 40);
                end else begin
                    burst_left--;
                end
                // Index 0 of the queue is the next request, since a handshake above already popped the consumed one.
                if (burst_on && pending_requests.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= pending_requests[0].kind;
                    s_axis_tdata <= {pending_requests[0].seen[63:0],
                                     pending_requests[0].seen[127:64],
                                     pending_requests[0].stamp[63:0],
                                     pending_requests[0].stamp[127:64]};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall on a rotating pattern and check each random block.
    always @(posedge i_clk) begin
        logic [127:0] want;
        cycle_count++;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                rand_seen++;
                if (expected_rands.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
                end else begin
                    want = expected_rands.pop_front();
                    if (m_axis_tdata[127:64] !== want[63:0])
                        report_mismatch("rand_low", m_axis_tdata[127:64], want[63:0]);
                    if (m_axis_tdata[63:0] !== want[127:64])
                        report_mismatch("rand_high", m_axis_tdata[63:0], want[127:64]);
                end
            end
            stall_phase = (stall_phase + 1) % 600;
            // Hold ready high for the first stretch of each stall_phase period, then stall at random.
            m_axis_tready <= (stall_phase < 150) || ($urandom_range(0, 3) != 0);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL x931_aes_random_generator_top");
            $finish;
        end
    end

    task automatic write_key(input logic [127:0] key);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= 1'b0;
        i_cfg_data <= key[127:64];
        @(posedge i_clk);
        i_cfg_index <= 1'b1;
        i_cfg_data <= key[63:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        key_model = key;
    endtask

    // Wait until every queued request is taken and every random block has arrived.
    task automatic drain();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_rands.size() != 0)
            @(posedge i_clk);
        // Let trailing resyncs in the engine and the queue finish.
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        t_item it;
        logic [127:0] keys [4];
        keys[0] = '0;
        keys[1] = '1;
        keys[2] = 128'h000102030405060708090a0b0c0d0e0f;
        keys[3] = {rand64(), rand64()};
        key_model = '0;
        seed_model = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: generate before any resync at reset key, extreme stamps, ignored seen fields.
        it.kind = KIND_GENERATE; it.stamp = '0; it.seen = '1;
        pending_requests.push_back(it);
        it.stamp = '1; it.seen = '0;
        pending_requests.push_back(it);
        it.kind = KIND_RESYNC; it.stamp = '0; it.seen = '0;
        pending_requests.push_back(it);
        it.kind = KIND_GENERATE; it.stamp = '0;
        pending_requests.push_back(it);
        it.kind = KIND_RESYNC; it.stamp = '1; it.seen = '1;
        pending_requests.push_back(it);
        it.kind = KIND_RESYNC; it.stamp = 128'h1; it.seen = {64'h0, 64'h8000000000000000};
        pending_requests.push_back(it);
        for (int i = 0; i < 6; i++) pending_requests.push_back(make_item(t_kind'(i % 2)));
        drain();

        // Key change keeps V: rotate through all-ones, counting and random keys.
        for (int k = 1; k < 4; k++) begin
            write_key(keys[k]);
            pending_requests.push_back(make_item(KIND_GENERATE));
            pending_requests.push_back(make_item(KIND_RESYNC));
            pending_requests.push_back(make_item(KIND_GENERATE));
            drain();
        end

        // Random phases: mostly generates, some resyncs, key swapped between phases.
        for (int p = 0; p < 6; p++) begin
            write_key(p == 5 ? 128'h0 : {rand64(), rand64()});
            for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
                it = make_item($urandom_range(0, 4) == 0 ? KIND_RESYNC : KIND_GENERATE);
                if (it.kind == KIND_RESYNC) resync_sent++;
                pending_requests.push_back(it);
            end
            drain();
        end

        $display("covered %0d random blocks, %0d random resyncs, key changes at idle",
                 rand_seen, resync_sent);
        if (error_count == 0 && expected_rands.size() == 0) begin
            $display("PASS x931_aes_random_generator_top");
        end else begin
            $display("FAIL x931_aes_random_generator_top");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/x931_pkg.sv
hw/rtl/x931_queue.sv
hw/rtl/x931_engine.sv
hw/rtl/x931_aes_random_generator_top.sv
tb/sv/x931_aes_random_generator_top_tb.sv
